>>> sv/circle_box_collision_test_macros.svh
// ----------------------------------------------------------------------------
// circle_box_collision_test assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_BOX_COLLISION_TEST_MACROS_SVH
`define CIRCLE_BOX_COLLISION_TEST_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("circle_box_collision_test: assertion failed");

// property checked at every clock edge, reset included
`define ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("circle_box_collision_test: assertion failed");

`else

`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ANY(label, clk, prop)

`endif

`endif

>>> sv/cbct_pkg.sv
// ----------------------------------------------------------------------------
// cbct_pkg
// Shared constants, register codes, width helpers and pipeline control type.
// ----------------------------------------------------------------------------
`default_nettype none

package cbct_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int OFFSET_BITS    = 16;
  localparam int SCALE_BITS     = 12;
  localparam int FRAC_SHIFT     = 8;   // Q4.8 scale fraction
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(256);

  // accepting edge to result strobe
  localparam int LATENCY = 7;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OFFSET_AX = 4'd0,
    REG_OFFSET_AY = 4'd1,
    REG_SCALE_AX  = 4'd2,
    REG_SCALE_AY  = 4'd3,
    REG_OFFSET_BX = 4'd4,
    REG_OFFSET_BY = 4'd5,
    REG_SCALE_BX  = 4'd6,
    REG_SCALE_BY  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic box_pair;
    logic box_hit;
  } pair_ctl_t;

  // 2*pos + size + 2*offset, in 1/2 pixel
  function automatic int c2_bits(int cb, int sb);
    int m;
    m = cb + 1;
    if (sb + 1 > m) m = sb + 1;
    if (OFFSET_BITS + 1 > m) m = OFFSET_BITS + 1;
    return m + 2;
  endfunction

  // scaled size, 1/512 pixel
  function automatic int half_bits(int sb);
    return sb + SCALE_BITS;
  endfunction

  // centre and box edges, 1/512 pixel
  function automatic int edge_bits(int cb, int sb);
    int m;
    m = c2_bits(cb, sb) + FRAC_SHIFT;
    if (half_bits(sb) + 1 > m) m = half_bits(sb) + 1;
    return m + 1;
  endfunction

endpackage

`default_nettype wire

>>> sv/cbct_shape.sv
// ----------------------------------------------------------------------------
// cbct_shape
// Two-stage geometry of one object: centre, box edges and circle radius.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_shape
  import cbct_pkg::*;
#(
  parameter int CB = COORD_BITS_DEF,
  parameter int SB = SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          kind,
  input  wire logic signed [CB-1:0]          px,
  input  wire logic signed [CB-1:0]          py,
  input  wire logic [SB-1:0]                 w,
  input  wire logic [SB-1:0]                 h,
  input  wire logic signed [OFFSET_BITS-1:0] ox,
  input  wire logic signed [OFFSET_BITS-1:0] oy,
  input  wire logic [SCALE_BITS-1:0]         sx,
  input  wire logic [SCALE_BITS-1:0]         sy,
  output logic                               kind_q,
  output logic signed [edge_bits(CB, SB)-1:0] cx,
  output logic signed [edge_bits(CB, SB)-1:0] cy,
  output logic signed [edge_bits(CB, SB)-1:0] lo_x,
  output logic signed [edge_bits(CB, SB)-1:0] hi_x,
  output logic signed [edge_bits(CB, SB)-1:0] lo_y,
  output logic signed [edge_bits(CB, SB)-1:0] hi_y,
  output logic [half_bits(SB)-1:0]           rad
);

  localparam int CW = c2_bits(CB, SB);
  localparam int HW = half_bits(SB);
  localparam int EW = edge_bits(CB, SB);

  // stage 1: doubled centre and scaled size
  logic signed [CW-1:0] c2x_next, c2y_next;
  logic signed [CW-1:0] c2x, c2y;
  logic [HW-1:0]        swx, swy;
  logic                 kind1;

  assign c2x_next = (CW'(px) <<< 1) + $signed(CW'(w)) + (CW'(ox) <<< 1);
  assign c2y_next = (CW'(py) <<< 1) + $signed(CW'(h)) + (CW'(oy) <<< 1);

  always_ff @(posedge clk) begin
    c2x   <= c2x_next;
    c2y   <= c2y_next;
    swx   <= HW'(w) * HW'(sx);
    swy   <= HW'(h) * HW'(sy);
    kind1 <= kind;
  end

  // stage 2: edges and radius
  logic signed [EW-1:0] cx_next, cy_next, hx, hy;

  assign cx_next = EW'(c2x) <<< FRAC_SHIFT;
  assign cy_next = EW'(c2y) <<< FRAC_SHIFT;
  assign hx      = $signed(EW'(swx));
  assign hy      = $signed(EW'(swy));

  always_ff @(posedge clk) begin
    kind_q <= kind1;
    cx     <= cx_next;
    cy     <= cy_next;
    lo_x   <= cx_next - hx;
    hi_x   <= cx_next + hx;
    lo_y   <= cy_next - hy;
    hi_y   <= cy_next + hy;
    rad    <= (swx > swy) ? swx : swy;
  end

endmodule

`default_nettype wire

>>> sv/cbct_select.sv
// ----------------------------------------------------------------------------
// cbct_select
// Picks circle and target roles, clamps, tests box overlap, forms distances.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_select
  import cbct_pkg::*;
#(
  parameter int CB = COORD_BITS_DEF,
  parameter int SB = SIZE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                kind_a,
  input  wire logic signed [edge_bits(CB, SB)-1:0] cx_a,
  input  wire logic signed [edge_bits(CB, SB)-1:0] cy_a,
  input  wire logic signed [edge_bits(CB, SB)-1:0] lo_xa,
  input  wire logic signed [edge_bits(CB, SB)-1:0] hi_xa,
  input  wire logic signed [edge_bits(CB, SB)-1:0] lo_ya,
  input  wire logic signed [edge_bits(CB, SB)-1:0] hi_ya,
  input  wire logic [half_bits(SB)-1:0]            rad_a,
  input  wire logic                                kind_b,
  input  wire logic signed [edge_bits(CB, SB)-1:0] cx_b,
  input  wire logic signed [edge_bits(CB, SB)-1:0] cy_b,
  input  wire logic signed [edge_bits(CB, SB)-1:0] lo_xb,
  input  wire logic signed [edge_bits(CB, SB)-1:0] hi_xb,
  input  wire logic signed [edge_bits(CB, SB)-1:0] lo_yb,
  input  wire logic signed [edge_bits(CB, SB)-1:0] hi_yb,
  input  wire logic [half_bits(SB)-1:0]            rad_b,
  output pair_ctl_t                                ctl,
  output logic [edge_bits(CB, SB)-1:0]             dx,
  output logic [edge_bits(CB, SB)-1:0]             dy,
  output logic [half_bits(SB):0]                   r
);

  localparam int EW = edge_bits(CB, SB);
  localparam int HW = half_bits(SB);

  // stage 3: roles, clamp and box overlap
  logic                 circ_b, both;
  logic signed [EW-1:0] ccx, ccy, tlo_x, thi_x, tlo_y, thi_y;
  logic signed [EW-1:0] mn_x, mn_y, qx_next, qy_next;
  logic [HW:0]          r_next;
  logic                 box_hit_next;
  pair_ctl_t            ctl3;
  logic signed [EW-1:0] qx, qy, ccx3, ccy3;
  logic [HW:0]          r3;

  assign circ_b = !kind_a && kind_b;
  assign both   = kind_a && kind_b;

  always_comb begin
    ccx = circ_b ? cx_b : cx_a;
    ccy = circ_b ? cy_b : cy_a;
    if (both) begin
      // the second circle acts as a point, its radius joins the first
      tlo_x = cx_b;
      thi_x = cx_b;
      tlo_y = cy_b;
      thi_y = cy_b;
      r_next = (HW + 1)'(rad_a) + (HW + 1)'(rad_b);
    end else if (circ_b) begin
      tlo_x = lo_xa;
      thi_x = hi_xa;
      tlo_y = lo_ya;
      thi_y = hi_ya;
      r_next = (HW + 1)'(rad_b);
    end else begin
      tlo_x = lo_xb;
      thi_x = hi_xb;
      tlo_y = lo_yb;
      thi_y = hi_yb;
      r_next = (HW + 1)'(rad_a);
    end
    mn_x    = (ccx < thi_x) ? ccx : thi_x;
    mn_y    = (ccy < thi_y) ? ccy : thi_y;
    qx_next = (tlo_x > mn_x) ? tlo_x : mn_x;
    qy_next = (tlo_y > mn_y) ? tlo_y : mn_y;
  end

  // strict overlap: each lower edge below both upper edges
  assign box_hit_next = (lo_xa < hi_xa) && (lo_xa < hi_xb) &&
                        (lo_xb < hi_xa) && (lo_xb < hi_xb) &&
                        (lo_ya < hi_ya) && (lo_ya < hi_yb) &&
                        (lo_yb < hi_ya) && (lo_yb < hi_yb);

  always_ff @(posedge clk) begin
    qx   <= qx_next;
    qy   <= qy_next;
    ccx3 <= ccx;
    ccy3 <= ccy;
    r3   <= r_next;
    ctl3.box_pair <= !kind_a && !kind_b;
    ctl3.box_hit  <= box_hit_next;
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= in_valid;
    end
  end

  // stage 4: absolute distances
  always_ff @(posedge clk) begin
    dx  <= (qx >= ccx3) ? EW'(qx - ccx3) : EW'(ccx3 - qx);
    dy  <= (qy >= ccy3) ? EW'(qy - ccy3) : EW'(ccy3 - qy);
    r   <= r3;
    ctl.box_pair <= ctl3.box_pair;
    ctl.box_hit  <= ctl3.box_hit;
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl3.valid;
    end
  end

endmodule

`default_nettype wire

>>> sv/cbct_square.sv
// ----------------------------------------------------------------------------
// cbct_square
// Two-stage squarer built from three half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module cbct_square #(
  parameter int W = 32
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   a,
  output logic [2*W-1:0]      sq
);

  localparam int K  = (W + 1) / 2;
  localparam int H  = W - K;
  localparam int HH = 2 * H;
  localparam int HL = H + K;
  localparam int LL = 2 * K;
  localparam int SW = 2 * W;

  logic [H-1:0]  a_hi;
  logic [K-1:0]  a_lo;
  logic [HH-1:0] pp_hh;
  logic [HL-1:0] pp_hl;
  logic [LL-1:0] pp_ll;

  assign a_hi = a[W-1:K];
  assign a_lo = a[K-1:0];

  always_ff @(posedge clk) begin
    pp_hh <= HH'(a_hi) * HH'(a_hi);
    pp_hl <= HL'(a_hi) * HL'(a_lo);
    pp_ll <= LL'(a_lo) * LL'(a_lo);
  end

  // cross term counts twice
  always_ff @(posedge clk) begin
    sq <= (SW'(pp_hh) << LL) + (SW'(pp_hl) << (K + 1)) + SW'(pp_ll);
  end

endmodule

`default_nettype wire

>>> sv/circle_box_collision_test.sv
// ----------------------------------------------------------------------------
// circle_box_collision_test
// Pipelined hit test between two objects, each a circle or a box.
// ----------------------------------------------------------------------------
// Usage:
//   A pair is taken at a clock edge with start high and busy low. busy is
//   high only while rst is high, so outside reset a new pair can be issued
//   every cycle, one per clock.
//   The hit flag appears on hit with done high for exactly one cycle, in
//   issue order, after the pipeline: two geometry stages per object, clamp
//   and overlap, distance, two stages of the partial-product squarers and
//   the final compare.
//   The receiver has no back-pressure: each result must be taken when done
//   is high.
//   Configuration registers are written through cfg_valid/cfg_ready with
//   cfg_index and cfg_data; write them only while no transaction is in flight.
//   Unknown indexes are ignored. cfg_ready is low only during reset.
//   Synchronous reset empties the pipeline (in-flight pairs are dropped) and
//   restores offsets to 0 and scales to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_box_collision_test_macros.svh"

module circle_box_collision_test
  import cbct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         kind_a,
  input  wire logic signed [COORD_BITS-1:0] pos_ax,
  input  wire logic signed [COORD_BITS-1:0] pos_ay,
  input  wire logic [SIZE_BITS-1:0]         width_a,
  input  wire logic [SIZE_BITS-1:0]         height_a,
  input  wire logic                         kind_b,
  input  wire logic signed [COORD_BITS-1:0] pos_bx,
  input  wire logic signed [COORD_BITS-1:0] pos_by,
  input  wire logic [SIZE_BITS-1:0]         width_b,
  input  wire logic [SIZE_BITS-1:0]         height_b,
  output logic                              done,
  output logic                              hit,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int EW = edge_bits(COORD_BITS, SIZE_BITS);
  localparam int HW = half_bits(SIZE_BITS);
  localparam int DW = 2 * EW + 1;

  // configuration registers
  logic signed [OFFSET_BITS-1:0] offset_ax, offset_ay, offset_bx, offset_by;
  logic [SCALE_BITS-1:0]         scale_ax, scale_ay, scale_bx, scale_by;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_ax <= '0;
      offset_ay <= '0;
      offset_bx <= '0;
      offset_by <= '0;
      scale_ax  <= SCALE_ONE;
      scale_ay  <= SCALE_ONE;
      scale_bx  <= SCALE_ONE;
      scale_by  <= SCALE_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_AX: offset_ax <= $signed(cfg_data[OFFSET_BITS-1:0]);
        REG_OFFSET_AY: offset_ay <= $signed(cfg_data[OFFSET_BITS-1:0]);
        REG_SCALE_AX:  scale_ax  <= cfg_data[SCALE_BITS-1:0];
        REG_SCALE_AY:  scale_ay  <= cfg_data[SCALE_BITS-1:0];
        REG_OFFSET_BX: offset_bx <= $signed(cfg_data[OFFSET_BITS-1:0]);
        REG_OFFSET_BY: offset_by <= $signed(cfg_data[OFFSET_BITS-1:0]);
        REG_SCALE_BX:  scale_bx  <= cfg_data[SCALE_BITS-1:0];
        REG_SCALE_BY:  scale_by  <= cfg_data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stages 1 and 2: per-object geometry
  logic                 v1, v2;
  logic                 kind_a2, kind_b2;
  logic signed [EW-1:0] cx_a, cy_a, lo_xa, hi_xa, lo_ya, hi_ya;
  logic signed [EW-1:0] cx_b, cy_b, lo_xb, hi_xb, lo_yb, hi_yb;
  logic [HW-1:0]        rad_a, rad_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
  end

  cbct_shape #(.CB(COORD_BITS), .SB(SIZE_BITS)) u_shape_a (
    .clk    (clk),
    .kind   (kind_a),
    .px     (pos_ax),
    .py     (pos_ay),
    .w      (width_a),
    .h      (height_a),
    .ox     (offset_ax),
    .oy     (offset_ay),
    .sx     (scale_ax),
    .sy     (scale_ay),
    .kind_q (kind_a2),
    .cx     (cx_a),
    .cy     (cy_a),
    .lo_x   (lo_xa),
    .hi_x   (hi_xa),
    .lo_y   (lo_ya),
    .hi_y   (hi_ya),
    .rad    (rad_a)
  );

  cbct_shape #(.CB(COORD_BITS), .SB(SIZE_BITS)) u_shape_b (
    .clk    (clk),
    .kind   (kind_b),
    .px     (pos_bx),
    .py     (pos_by),
    .w      (width_b),
    .h      (height_b),
    .ox     (offset_bx),
    .oy     (offset_by),
    .sx     (scale_bx),
    .sy     (scale_by),
    .kind_q (kind_b2),
    .cx     (cx_b),
    .cy     (cy_b),
    .lo_x   (lo_xb),
    .hi_x   (hi_xb),
    .lo_y   (lo_yb),
    .hi_y   (hi_yb),
    .rad    (rad_b)
  );

  // stages 3 and 4: roles, clamp, overlap, distances
  pair_ctl_t     ctl4, ctl5, ctl6;
  logic [EW-1:0] dx, dy;
  logic [HW:0]   r4;

  cbct_select #(.CB(COORD_BITS), .SB(SIZE_BITS)) u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .kind_a   (kind_a2),
    .cx_a     (cx_a),
    .cy_a     (cy_a),
    .lo_xa    (lo_xa),
    .hi_xa    (hi_xa),
    .lo_ya    (lo_ya),
    .hi_ya    (hi_ya),
    .rad_a    (rad_a),
    .kind_b   (kind_b2),
    .cx_b     (cx_b),
    .cy_b     (cy_b),
    .lo_xb    (lo_xb),
    .hi_xb    (hi_xb),
    .lo_yb    (lo_yb),
    .hi_yb    (hi_yb),
    .rad_b    (rad_b),
    .ctl      (ctl4),
    .dx       (dx),
    .dy       (dy),
    .r        (r4)
  );

  // stages 5 and 6: squares
  logic [2*EW-1:0]     sq_x, sq_y;
  logic [2*(HW+1)-1:0] sq_r;

  cbct_square #(.W(EW)) u_square_x (
    .clk (clk),
    .a   (dx),
    .sq  (sq_x)
  );

  cbct_square #(.W(EW)) u_square_y (
    .clk (clk),
    .a   (dy),
    .sq  (sq_y)
  );

  cbct_square #(.W(HW + 1)) u_square_r (
    .clk (clk),
    .a   (r4),
    .sq  (sq_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
      ctl6 <= '0;
    end else begin
      ctl5 <= ctl4;
      ctl6 <= ctl5;
    end
  end

  // stage 7: final compare
  logic [DW-1:0] dist2;
  logic          hit_next;

  assign dist2    = DW'(sq_x) + DW'(sq_y);
  assign hit_next = ctl6.box_pair ? ctl6.box_hit : (dist2 <= DW'(sq_r));

  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl6.valid;
    end
  end

  // every accepted transaction yields exactly one result
  `ASSERT_RST(a_result_follows, clk, rst, (start && !busy) |-> ##LATENCY done)
  `ASSERT_RST(a_result_has_cause, clk, rst, done |-> $past(start && !busy, LATENCY))
  // a box of zero width can never overlap another box
  `ASSERT_RST(a_flat_box_misses, clk, rst,
      (start && !busy && !kind_a && !kind_b && (width_a == '0)) |->
      ##LATENCY (done && !hit))
  `ASSERT_ANY(a_reset_flushes, clk, $past(rst) |-> !done)

endmodule

`default_nettype wire

>>> dv/circle_box_collision_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_box_collision_test_tb
// Streams object pairs through the collision tester and checks every hit flag
// against a predictor kept in exact fixed point. Register settings change
// between phases once the pipeline has drained. The settings include zero and
// full scale, extreme offsets and writes to unused register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_box_collision_test_tb
  import cbct_pkg::*;
;

  localparam int CB          = COORD_BITS_DEF;
  localparam int SB          = SIZE_BITS_DEF;
  localparam int MIN_POS     = -(1 << (CB - 1));
  localparam int MAX_POS     = (1 << (CB - 1)) - 1;
  localparam int MAX_SIZE    = (1 << SB) - 1;
  localparam int STALL_LIMIT = 1000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_PAIRS = 180;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI = 4'd15;

  typedef enum logic {
    SHAPE_BOX    = 1'b0,
    SHAPE_CIRCLE = 1'b1
  } obj_kind_t;

  typedef enum logic [1:0] {
    JOB_PAIR,
    JOB_CFG,
    JOB_SYNC
  } job_kind_t;

  typedef struct {
    obj_kind_t             kind;
    logic signed [CB-1:0]  px;
    logic signed [CB-1:0]  py;
    logic [SB-1:0]         w;
    logic [SB-1:0]         h;
  } obj_t;

  typedef struct {
    logic signed [OFFSET_BITS-1:0] ox;
    logic signed [OFFSET_BITS-1:0] oy;
    logic [SCALE_BITS-1:0]         sx;
    logic [SCALE_BITS-1:0]         sy;
  } geom_cfg_t;

  // lengths in 1/512 pixel
  typedef struct {
    logic   circ;
    longint cx;
    longint cy;
    longint hx;
    longint hy;
    longint rad;
  } shape_t;

  typedef struct {
    job_kind_t                  kind;
    bit                         eager;
    obj_t                       a;
    obj_t                       b;
    logic [CFG_INDEX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0]   data;
  } job_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    kind_a = 1'b0;
  logic signed [CB-1:0]    pos_ax = '0;
  logic signed [CB-1:0]    pos_ay = '0;
  logic [SB-1:0]           width_a = '0;
  logic [SB-1:0]           height_a = '0;
  logic                    kind_b = 1'b0;
  logic signed [CB-1:0]    pos_bx = '0;
  logic signed [CB-1:0]    pos_by = '0;
  logic [SB-1:0]           width_b = '0;
  logic [SB-1:0]           height_b = '0;
  logic                    done;
  logic                    hit;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  job_t      pending_jobs[$];
  logic      expected_hits[$];
  geom_cfg_t cfg_a = '{ox: '0, oy: '0, sx: SCALE_ONE, sy: SCALE_ONE};
  geom_cfg_t cfg_b = '{ox: '0, oy: '0, sx: SCALE_ONE, sy: SCALE_ONE};
  int        errors = 0;
  int        pairs_seen = 0;
  int        hits_seen = 0;
  int        writes_seen = 0;
  int        combo_cnt[4] = '{0, 0, 0, 0};
  int        stall_cycles = 0;

  circle_box_collision_test u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind_a    (kind_a),
    .pos_ax    (pos_ax),
    .pos_ay    (pos_ay),
    .width_a   (width_a),
    .height_a  (height_a),
    .kind_b    (kind_b),
    .pos_bx    (pos_bx),
    .pos_by    (pos_by),
    .width_b   (width_b),
    .height_b  (height_b),
    .done      (done),
    .hit       (hit),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [127:0] square(longint d);
    logic [127:0] m;
    m = 128'(d < 0 ? -d : d);
    return m * m;
  endfunction

  function automatic shape_t place(obj_t o, geom_cfg_t g);
    shape_t s;
    longint sw;
    longint sh;
    sw = longint'(o.w) * longint'(g.sx);
    sh = longint'(o.h) * longint'(g.sy);
    s.circ = (o.kind == SHAPE_CIRCLE);
    s.cx = (2 * longint'(o.px) + longint'(o.w) + 2 * longint'(g.ox)) * 256;
    s.cy = (2 * longint'(o.py) + longint'(o.h) + 2 * longint'(g.oy)) * 256;
    s.hx = sw;
    s.hy = sh;
    s.rad = (sw > sh) ? sw : sh;
    return s;
  endfunction

  // nearest point of the box to the circle centre
  function automatic logic circ_vs_box(shape_t c, shape_t b);
    longint qx;
    longint qy;
    qx = (c.cx < b.cx + b.hx) ? c.cx : b.cx + b.hx;
    if (qx < b.cx - b.hx) qx = b.cx - b.hx;
    qy = (c.cy < b.cy + b.hy) ? c.cy : b.cy + b.hy;
    if (qy < b.cy - b.hy) qy = b.cy - b.hy;
    return (square(qx - c.cx) + square(qy - c.cy)) <= square(c.rad);
  endfunction

  // strict overlap, touching edges miss
  function automatic logic box_vs_box(shape_t a, shape_t b);
    longint l;
    longint r;
    longint t;
    longint u;
    l = (a.cx - a.hx > b.cx - b.hx) ? a.cx - a.hx : b.cx - b.hx;
    r = (a.cx + a.hx < b.cx + b.hx) ? a.cx + a.hx : b.cx + b.hx;
    t = (a.cy - a.hy > b.cy - b.hy) ? a.cy - a.hy : b.cy - b.hy;
    u = (a.cy + a.hy < b.cy + b.hy) ? a.cy + a.hy : b.cy + b.hy;
    return (l < r) && (t < u);
  endfunction

  function automatic logic collide(obj_t a, obj_t b);
    shape_t sh_a;
    shape_t sh_b;
    sh_a = place(a, cfg_a);
    sh_b = place(b, cfg_b);
    if (sh_a.circ && sh_b.circ) begin
      return (square(sh_a.cx - sh_b.cx) + square(sh_a.cy - sh_b.cy))
             <= square(sh_a.rad + sh_b.rad);
    end else if (sh_a.circ) begin
      return circ_vs_box(sh_a, sh_b);
    end else if (sh_b.circ) begin
      return circ_vs_box(sh_b, sh_a);
    end
    return box_vs_box(sh_a, sh_b);
  endfunction

  // ---------------------------------------------------------------- job queue

  function automatic obj_t shape_at(obj_kind_t k, int px, int py, int w, int h);
    obj_t o;
    o.kind = k;
    o.px = CB'(px);
    o.py = CB'(py);
    o.w = SB'(w);
    o.h = SB'(h);
    return o;
  endfunction

  task automatic push_pair(obj_t a, obj_t b, bit eager);
    job_t j;
    j.kind = JOB_PAIR;
    j.eager = eager;
    j.a = a;
    j.b = b;
    pending_jobs.push_back(j);
  endtask

  task automatic push_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    job_t j;
    j.kind = JOB_CFG;
    j.eager = 1'b0;
    j.idx = idx;
    j.data = data;
    pending_jobs.push_back(j);
  endtask

  task automatic push_sync();
    job_t j;
    j.kind = JOB_SYNC;
    j.eager = 1'b0;
    pending_jobs.push_back(j);
  endtask

  // half of the picks are zero or small offsets so that neighbouring objects still meet
  function automatic logic [CFG_DATA_BITS-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return CFG_DATA_BITS'($urandom());
      3: return '0;
      default: return CFG_DATA_BITS'(int'($urandom_range(0, 127)) - 64);
    endcase
  endfunction

  // bits above the scale width must be ignored
  function automatic logic [CFG_DATA_BITS-1:0] pick_scale();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'hffff;
      2, 3: return CFG_DATA_BITS'(SCALE_ONE);
      4, 5: return CFG_DATA_BITS'($urandom_range(64, 768));
      default: return CFG_DATA_BITS'($urandom());
    endcase
  endfunction

  function automatic obj_t rand_obj();
    obj_t o;
    o.kind = obj_kind_t'($urandom_range(0, 1));
    o.px = CB'($urandom());
    o.py = CB'($urandom());
    o.w = SB'($urandom());
    o.h = SB'($urandom());
    return o;
  endfunction

  task automatic push_random_pair(bit eager);
    obj_t a;
    obj_t b;
    int   mode;
    int   lim;
    int   span_x;
    int   span_y;
    a = rand_obj();
    b = rand_obj();
    mode = $urandom_range(0, 9);
    if (mode >= 2) begin
      lim = (mode == 2) ? MAX_SIZE : 600;
      a.w = SB'($urandom_range(0, lim));
      a.h = SB'($urandom_range(0, lim));
      b.w = SB'($urandom_range(0, lim));
      b.h = SB'($urandom_range(0, lim));
      span_x = int'(a.w) + int'(b.w) + 32;
      span_y = int'(a.h) + int'(b.h) + 32;
      b.px = CB'(int'(a.px) + int'($urandom_range(0, 2 * span_x)) - span_x);
      b.py = CB'(int'(a.py) + int'($urandom_range(0, 2 * span_y)) - span_y);
      // right edge of a against left edge of b
      if (mode == 3) b.px = CB'(int'(a.px) + int'(a.w));
    end
    push_pair(a, b, eager);
  endtask

  // ------------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_proc
    logic nxt_start;
    logic nxt_cfg;
    logic gap;
    job_t j;
    nxt_start = start;
    nxt_cfg = cfg_valid;
    if (!rst) begin
      if (start && !busy) begin
        pending_jobs.delete(0);
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        pending_jobs.delete(0);
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && pending_jobs.size() != 0) begin
        j = pending_jobs[0];
        gap = !j.eager && ($urandom_range(0, 99) < 34);
        case (j.kind)
          JOB_SYNC: begin
            // a pair taken at this edge is not in the expected queue yet
            if (!start && expected_hits.size() == 0) pending_jobs.delete(0);
          end
          JOB_PAIR: begin
            if (!gap) begin
              kind_a   <= j.a.kind;
              pos_ax   <= j.a.px;
              pos_ay   <= j.a.py;
              width_a  <= j.a.w;
              height_a <= j.a.h;
              kind_b   <= j.b.kind;
              pos_bx   <= j.b.px;
              pos_by   <= j.b.py;
              width_b  <= j.b.w;
              height_b <= j.b.h;
              nxt_start = 1'b1;
            end
          end
          JOB_CFG: begin
            if (!gap) begin
              cfg_index <= j.idx;
              cfg_data  <= j.data;
              nxt_cfg = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin : check_proc
    obj_t a;
    obj_t b;
    if (!rst) begin
      if (done) begin
        if (expected_hits.size() == 0) begin
          $error("hit: no result expected, got %0b", hit);
          errors++;
        end else begin
          if (hit !== expected_hits[0]) begin
            $error("hit: expected %0b, got %0b", expected_hits[0], hit);
            errors++;
          end
          if (hit === 1'b1) hits_seen++;
          expected_hits.delete(0);
        end
      end
      if (start && !busy) begin
        a.kind = obj_kind_t'(kind_a);
        a.px = pos_ax;
        a.py = pos_ay;
        a.w = width_a;
        a.h = height_a;
        b.kind = obj_kind_t'(kind_b);
        b.px = pos_bx;
        b.py = pos_by;
        b.w = width_b;
        b.h = height_b;
        expected_hits.push_back(collide(a, b));
        combo_cnt[{kind_a, kind_b}]++;
        pairs_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET_AX: cfg_a.ox = cfg_data[OFFSET_BITS-1:0];
          REG_OFFSET_AY: cfg_a.oy = cfg_data[OFFSET_BITS-1:0];
          REG_SCALE_AX:  cfg_a.sx = cfg_data[SCALE_BITS-1:0];
          REG_SCALE_AY:  cfg_a.sy = cfg_data[SCALE_BITS-1:0];
          REG_OFFSET_BX: cfg_b.ox = cfg_data[OFFSET_BITS-1:0];
          REG_OFFSET_BY: cfg_b.oy = cfg_data[OFFSET_BITS-1:0];
          REG_SCALE_BX:  cfg_b.sx = cfg_data[SCALE_BITS-1:0];
          REG_SCALE_BY:  cfg_b.sy = cfg_data[SCALE_BITS-1:0];
          default: ;
        endcase
        writes_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done ||
        (pending_jobs.size() == 0 && expected_hits.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stim_proc
    int ph;
    int n;

    // reset settings: edges, touching and degenerate shapes
    push_pair(shape_at(SHAPE_BOX, 0, 0, 16, 16), shape_at(SHAPE_BOX, 16, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_BOX, 0, 0, 16, 16), shape_at(SHAPE_BOX, 15, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_BOX, 0, 0, 16, 16), shape_at(SHAPE_BOX, 0, 16, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, 0, 0, 16, 16),
              shape_at(SHAPE_CIRCLE, 16, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, 0, 0, 16, 16),
              shape_at(SHAPE_CIRCLE, 17, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, 0, 0, 16, 16), shape_at(SHAPE_BOX, 16, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_BOX, 0, 0, 16, 16), shape_at(SHAPE_CIRCLE, 17, 17, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_BOX, 0, 0, 0, 0), shape_at(SHAPE_BOX, 0, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, 8, 8, 0, 0), shape_at(SHAPE_BOX, 0, 0, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, -5, -5, 0, 0), shape_at(SHAPE_CIRCLE, -5, -5, 0, 0), 1'b0);
    push_pair(shape_at(SHAPE_BOX, MIN_POS, MIN_POS, MAX_SIZE, MAX_SIZE),
              shape_at(SHAPE_BOX, MAX_POS, MAX_POS, MAX_SIZE, MAX_SIZE), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, MAX_POS, MIN_POS, MAX_SIZE, 0),
              shape_at(SHAPE_BOX, MAX_POS, MIN_POS, 0, MAX_SIZE), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, MIN_POS, MAX_POS, MAX_SIZE, MAX_SIZE),
              shape_at(SHAPE_CIRCLE, MIN_POS, MAX_POS, MAX_SIZE, MAX_SIZE), 1'b0);

    // zero scale, opposite extreme offsets: both centres land on one point
    push_sync();
    push_cfg(REG_SCALE_AX, '0);
    push_cfg(REG_SCALE_AY, '0);
    push_cfg(REG_SCALE_BX, '0);
    push_cfg(REG_SCALE_BY, '0);
    push_cfg(REG_OFFSET_AX, 16'h7fff);
    push_cfg(REG_OFFSET_AY, 16'h7fff);
    push_cfg(REG_OFFSET_BX, 16'h8000);
    push_cfg(REG_OFFSET_BY, 16'h8000);
    push_cfg(REG_UNUSED_LO, 16'hffff);
    push_pair(shape_at(SHAPE_CIRCLE, 0, 0, 16, 16),
              shape_at(SHAPE_CIRCLE, 65535, 65535, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, 0, 0, 16, 16),
              shape_at(SHAPE_BOX, 65535, 65535, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_BOX, 0, 0, 16, 16),
              shape_at(SHAPE_BOX, 65535, 65535, 16, 16), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, 0, 0, 16, 16),
              shape_at(SHAPE_CIRCLE, 65536, 65535, 16, 16), 1'b0);

    // full scale with the upper data bits set
    push_sync();
    push_cfg(REG_SCALE_AX, 16'hffff);
    push_cfg(REG_SCALE_AY, 16'hffff);
    push_cfg(REG_SCALE_BX, 16'hffff);
    push_cfg(REG_SCALE_BY, 16'hffff);
    push_cfg(REG_OFFSET_AX, '0);
    push_cfg(REG_OFFSET_AY, '0);
    push_cfg(REG_OFFSET_BX, '0);
    push_cfg(REG_OFFSET_BY, '0);
    push_cfg(REG_UNUSED_HI, 16'h1234);
    push_pair(shape_at(SHAPE_BOX, MIN_POS, MIN_POS, MAX_SIZE, MAX_SIZE),
              shape_at(SHAPE_BOX, MAX_POS, MAX_POS, MAX_SIZE, MAX_SIZE), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, MIN_POS, MIN_POS, MAX_SIZE, MAX_SIZE),
              shape_at(SHAPE_CIRCLE, MAX_POS, MAX_POS, MAX_SIZE, MAX_SIZE), 1'b0);
    push_pair(shape_at(SHAPE_BOX, MIN_POS, 0, MAX_SIZE, 1),
              shape_at(SHAPE_CIRCLE, MAX_POS, 0, MAX_SIZE, 0), 1'b0);
    push_pair(shape_at(SHAPE_CIRCLE, MAX_POS, MAX_POS, 0, MAX_SIZE),
              shape_at(SHAPE_BOX, MIN_POS, MIN_POS, MAX_SIZE, 0), 1'b0);

    // random phases, the first back at reset values, one without gaps
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      push_sync();
      push_cfg(REG_OFFSET_AX, (ph == 0) ? '0 : pick_offset());
      push_cfg(REG_OFFSET_AY, (ph == 0) ? '0 : pick_offset());
      push_cfg(REG_SCALE_AX, (ph == 0) ? CFG_DATA_BITS'(SCALE_ONE) : pick_scale());
      push_cfg(REG_SCALE_AY, (ph == 0) ? CFG_DATA_BITS'(SCALE_ONE) : pick_scale());
      push_cfg(REG_OFFSET_BX, (ph == 0) ? '0 : pick_offset());
      push_cfg(REG_OFFSET_BY, (ph == 0) ? '0 : pick_offset());
      push_cfg(REG_SCALE_BX, (ph == 0) ? CFG_DATA_BITS'(SCALE_ONE) : pick_scale());
      push_cfg(REG_SCALE_BY, (ph == 0) ? CFG_DATA_BITS'(SCALE_ONE) : pick_scale());
      if ($urandom_range(0, 1) == 1) begin
        push_cfg(CFG_INDEX_BITS'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                 CFG_DATA_BITS'($urandom()));
      end
      for (n = 0; n < PHASE_PAIRS; n++) push_random_pair(ph == 4);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_jobs.size() != 0 || expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d pairs, %0d hits, %0d register transactions",
             pairs_seen, hits_seen, writes_seen);
    $display("box/box %0d, box/circle %0d, circle/box %0d, circle/circle %0d",
             combo_cnt[0], combo_cnt[1], combo_cnt[2], combo_cnt[3]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
